FILE: rtl/core/hsvrgb_pkg.sv
// Shared types and constants for the HSV to RGB converter.
// No dependencies; imported by every module of the block.
package hsvrgb_pkg;

	// Hue units per 60 degree sector (1/64 degree each)
	localparam logic [14:0] SECTOR_UNITS = 15'd3840;
	// Number of sector boundaries a 15-bit hue can cross
	localparam int SECTOR_MAX = 8;
	// Fixed-point one for saturation and value
	localparam logic [8:0] ONE_8 = 9'd256;
	// Fraction reciprocal: f16 = (rem * FRAC_RECIP) >> FRAC_SHIFT == rem*256/15
	localparam logic [19:0] FRAC_RECIP = 20'd559241;
	localparam int FRAC_SHIFT = 15;
	// Fixed-point one at scale 2^24 and 2^16
	localparam logic [24:0] ONE_24 = 25'h100_0000;
	localparam logic [16:0] ONE_16 = 17'h1_0000;
	// Cycles from request acceptance to result strobe
	localparam int PIPE_LATENCY = 5;

	// Sector codes; anything above SECT_4 routes as the last sector
	localparam logic [3:0] SECT_0 = 4'd0;
	localparam logic [3:0] SECT_1 = 4'd1;
	localparam logic [3:0] SECT_2 = 4'd2;
	localparam logic [3:0] SECT_3 = 4'd3;
	localparam logic [3:0] SECT_4 = 4'd4;

	// Sector decode result handed to the pipeline
	typedef struct packed {
		logic [3:0]  sector;
		logic [11:0] rem;
	} sector_info_t;

endpackage

FILE: rtl/core/hsvrgb_sector.sv
// Hue sector decode: sector = hue / 3840 and the remainder within it.
// Depends on hsvrgb_pkg.
module hsvrgb_sector import hsvrgb_pkg::*; (
	input  logic [14:0]  hue,
	output sector_info_t info
);

	logic [SECTOR_MAX-1:0] above;
	logic [3:0]            sector;
	logic [14:0]           base;
	logic [14:0]           diff;

	// Compare hue against every sector boundary in parallel
	always_comb begin
		for (int k = 0; k < SECTOR_MAX; k++) begin
			above[k] = (hue >= 15'(k + 1) * SECTOR_UNITS);
		end
	end

	// Boundaries are monotonic, so the count of crossed ones is the sector
	always_comb begin
		sector = 4'd0;
		for (int k = 0; k < SECTOR_MAX; k++) begin
			sector = sector + {3'd0, above[k]};
		end
	end

	// Subtract the sector base to get the remainder
	assign base = {11'd0, sector} * SECTOR_UNITS;
	assign diff = hue - base;

	assign info.sector = sector;
	assign info.rem    = diff[11:0];

endmodule

FILE: rtl/core/hsv_to_rgb_converter.sv
// HSV to RGB converter, top level: a five stage pipeline.
// An accepted request's result moves through the stage 1 to stage 5 registers and is shown with done.
// Throughput: one request per cycle; busy is tied low.
// The receiver cannot stall; every result is strobed for exactly one cycle.
// Reset (arst_n low, asynchronous) clears all stage valid bits; data regs hold.
// Depends on hsvrgb_pkg and hsvrgb_sector.
module hsv_to_rgb_converter import hsvrgb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [14:0] hue,
	input  logic [8:0]  saturation,
	input  logic [8:0]  brightness,
	output logic        done,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue
);

	logic         accept;
	sector_info_t sec_info;
	logic [8:0]   sat_cl;
	logic [8:0]   val_cl;

	// Stage 1: clamped inputs and sector decode
	logic         vld_s1;
	logic [3:0]   sector_s1;
	logic [11:0]  rem_s1;
	logic [8:0]   sat_s1;
	logic [8:0]   val_s1;

	// Stage 2: fraction, p product, value channel
	logic         vld_s2;
	logic [3:0]   sector_s2;
	logic [15:0]  frac_s2;
	logic [8:0]   sat_s2;
	logic [8:0]   val_s2;
	logic [16:0]  p_raw_s2;
	logic [7:0]   cv_s2;
	logic [31:0]  frac_prod;
	logic [17:0]  p_prod;
	logic [16:0]  cv_prod;

	// Stage 3: complements for q and t, p channel
	logic         vld_s3;
	logic [3:0]   sector_s3;
	logic [8:0]   val_s3;
	logic         gray_s3;
	logic [24:0]  aq_s3;
	logic [24:0]  at_s3;
	logic [7:0]   cp_s3;
	logic [7:0]   cv_s3;
	logic [24:0]  sf;
	logic [16:0]  frac_c;
	logic [25:0]  sfc;
	logic [25:0]  p_scaled;

	// Stage 4: q and t products
	logic         vld_s4;
	logic [3:0]   sector_s4;
	logic         gray_s4;
	logic [32:0]  q_raw_s4;
	logic [32:0]  t_raw_s4;
	logic [7:0]   cp_s4;
	logic [7:0]   cv_s4;
	logic [33:0]  q_prod;
	logic [33:0]  t_prod;

	// Stage 5: outputs
	logic         vld_s5;
	logic [7:0]   red_s5;
	logic [7:0]   green_s5;
	logic [7:0]   blue_s5;
	logic [40:0]  q_scaled;
	logic [40:0]  t_scaled;
	logic [7:0]   cq;
	logic [7:0]   ct;
	logic [7:0]   r_n;
	logic [7:0]   g_n;
	logic [7:0]   b_n;

	// Accept a request every cycle
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	hsvrgb_sector u_sector (
		.hue  (hue),
		.info (sec_info)
	);

	// Saturate saturation and value at 1.0
	assign sat_cl = (saturation > ONE_8) ? ONE_8 : saturation;
	assign val_cl = (brightness > ONE_8) ? ONE_8 : brightness;

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// Stage 1: capture the request
	always_ff @(posedge clk) begin
		if (accept) begin
			sector_s1 <= sec_info.sector;
			rem_s1    <= sec_info.rem;
			sat_s1    <= sat_cl;
			val_s1    <= val_cl;
		end
	end

	// Stage 2: fraction by reciprocal, p = v(1-s), value channel
	assign frac_prod = {20'd0, rem_s1} * {12'd0, FRAC_RECIP};
	assign p_prod    = {9'd0, val_s1} * {9'd0, ONE_8 - sat_s1};
	assign cv_prod   = ({8'd0, val_s1} << 8) - {8'd0, val_s1};

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			sector_s2 <= sector_s1;
			frac_s2   <= frac_prod[FRAC_SHIFT +: 16];
			sat_s2    <= sat_s1;
			val_s2    <= val_s1;
			p_raw_s2  <= p_prod[16:0];
			cv_s2     <= cv_prod[15:8];
		end
	end

	// Stage 3: 1 - s*f and 1 - s*(1-f) at scale 2^24, p channel
	assign sf       = {16'd0, sat_s2} * {9'd0, frac_s2};
	assign frac_c   = ONE_16 - {1'b0, frac_s2};
	assign sfc      = {17'd0, sat_s2} * {9'd0, frac_c};
	assign p_scaled = ({9'd0, p_raw_s2} << 8) - {9'd0, p_raw_s2};

	always_ff @(posedge clk) begin
		if (vld_s2) begin
			sector_s3 <= sector_s2;
			val_s3    <= val_s2;
			gray_s3   <= (sat_s2 == 9'd0);
			aq_s3     <= ONE_24 - sf;
			at_s3     <= ONE_24 - sfc[24:0];
			cp_s3     <= p_scaled[23:16];
			cv_s3     <= cv_s2;
		end
	end

	// Stage 4: scale q and t by value
	assign q_prod = {25'd0, val_s3} * {9'd0, aq_s3};
	assign t_prod = {25'd0, val_s3} * {9'd0, at_s3};

	always_ff @(posedge clk) begin
		if (vld_s3) begin
			sector_s4 <= sector_s3;
			gray_s4   <= gray_s3;
			q_raw_s4  <= q_prod[32:0];
			t_raw_s4  <= t_prod[32:0];
			cp_s4     <= cp_s3;
			cv_s4     <= cv_s3;
		end
	end

	// Stage 5: channels are floor(x*255 / 2^32); route by sector
	assign q_scaled = ({8'd0, q_raw_s4} << 8) - {8'd0, q_raw_s4};
	assign t_scaled = ({8'd0, t_raw_s4} << 8) - {8'd0, t_raw_s4};
	assign cq       = q_scaled[39:32];
	assign ct       = t_scaled[39:32];

	always_comb begin
		case (sector_s4)
			SECT_0: begin
				r_n = cv_s4; g_n = ct;    b_n = cp_s4;
			end
			SECT_1: begin
				r_n = cq;    g_n = cv_s4; b_n = cp_s4;
			end
			SECT_2: begin
				r_n = cp_s4; g_n = cv_s4; b_n = ct;
			end
			SECT_3: begin
				r_n = cp_s4; g_n = cq;    b_n = cv_s4;
			end
			SECT_4: begin
				r_n = ct;    g_n = cp_s4; b_n = cv_s4;
			end
			default: begin
				r_n = cv_s4; g_n = cp_s4; b_n = cq;
			end
		endcase
		// Zero saturation is plain gray
		if (gray_s4) begin
			r_n = cv_s4;
			g_n = cv_s4;
			b_n = cv_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s4) begin
			red_s5   <= r_n;
			green_s5 <= g_n;
			blue_s5  <= b_n;
		end
	end

	assign done  = vld_s5;
	assign red   = red_s5;
	assign green = green_s5;
	assign blue  = blue_s5;

endmodule

FILE: rtl/core/hsvrgb_checker.sv
// Port-level checks for the HSV to RGB converter, bound to the top level.
// Depends on hsvrgb_pkg and hsv_to_rgb_converter.
module hsvrgb_checker import hsvrgb_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [14:0] hue,
	input logic [8:0]  saturation,
	input logic [8:0]  brightness,
	input logic        done,
	input logic [7:0]  red,
	input logic [7:0]  green,
	input logic [7:0]  blue
);

	logic [2:0] warm_q;
	logic       warm;

	// Count cycles since reset so history checks skip the reset window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warm_q <= 3'd0;
		end else if (warm_q != 3'(PIPE_LATENCY)) begin
			warm_q <= warm_q + 3'd1;
		end
	end

	assign warm = (warm_q == 3'(PIPE_LATENCY));

	// The block never holds off a request
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy asserted");

	// One result per request, a fixed latency later
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		warm |-> (done == $past(start && !busy, PIPE_LATENCY)))
		else $error("result strobe does not match request history");

	// Zero saturation gives gray
	a_gray: assert property (@(posedge clk) disable iff (!arst_n)
		(warm && $past(start && !busy && saturation == 9'd0, PIPE_LATENCY))
		|-> (red == green && green == blue))
		else $error("zero saturation not gray");

	// Zero brightness gives black
	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		(warm && $past(start && !busy && brightness == 9'd0, PIPE_LATENCY))
		|-> (red == 8'd0 && green == 8'd0 && blue == 8'd0))
		else $error("zero brightness not black");

	// Full red at hue zero with full saturation and brightness
	a_red: assert property (@(posedge clk) disable iff (!arst_n)
		(warm && $past(start && !busy && hue == 15'd0 && saturation >= 9'd256
			&& brightness >= 9'd256, PIPE_LATENCY))
		|-> (red == 8'd255 && green == 8'd0 && blue == 8'd0))
		else $error("pure red mismatch");

endmodule

bind hsv_to_rgb_converter hsvrgb_checker u_hsvrgb_checker (.*);
